[rtl/assert_macros.svh]
// Assertion macros for the RTL of the covariance kernel.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define AEK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kernel assertion failed");

// Checks that a condition leads to another one in the next cycle.
`define AEK_ASSERT_NEXT(lbl, pre, post) `AEK_ASSERT(lbl, (pre) |=> (post))

`endif

[rtl/aek_pkg.sv]
// Constants, types and the root table for the anisotropic exponential kernel.
// Depends on nothing; used by every module of the kernel.
package aek_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CAP_BITS  = 7;
  localparam int AW        = FRAC_BITS + CAP_BITS;
  localparam int RW        = AW + 1;
  localparam int RADW      = 2 * RW;
  localparam int PW        = 65 - FRAC_BITS;
  localparam int SQ_STEP   = 4;
  localparam int SQ_STAGES = (RW + SQ_STEP - 1) / SQ_STEP;
  localparam int ZHW       = RW - FRAC_BITS - 1;
  localparam int YW        = ZHW + 33;
  localparam int NW        = ZHW + 1;
  localparam int EXP_STAGES = 33;
  localparam int LAT       = 6 + SQ_STAGES + 3 + EXP_STAGES + 1;

  localparam logic [30:0] LOG2E_FRAC = 31'h71547653;

  typedef enum logic [1:0] {
    REG_L00      = 2'd0,
    REG_L01      = 2'd1,
    REG_L11      = 2'd2,
    REG_VARIANCE = 2'd3
  } cfg_reg_e;

  typedef logic [31:0] root_tab_t [0:32];

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = x;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic root_tab_t build_root_tab();
    root_tab_t t;
    logic [63:0] r;
    t[0] = '0;
    r    = isqrt64(64'h8000_0000_0000_0000);
    t[1] = r[31:0];
    for (int k = 2; k <= 32; k++) begin
      r    = isqrt64({t[k-1], 32'h0});
      t[k] = r[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_root_tab();

endpackage

[rtl/aek_sqrt.sv]
// Pipelined integer square root, several result bits per stage.
// Depends on aek_pkg.
module aek_sqrt (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [aek_pkg::RADW-1:0] rad_i,
  input  logic                    sat_i,
  output logic [aek_pkg::RW-1:0]   root_o,
  output logic                    sat_o
);
  import aek_pkg::*;

  logic [RADW-1:0] rad_q  [0:SQ_STAGES-1];
  logic [RW+2:0]   rem_q  [0:SQ_STAGES-1];
  logic [RW-1:0]   root_q [0:SQ_STAGES-1];
  logic            sat_q  [0:SQ_STAGES-1];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    logic [RADW-1:0] rad_in;
    logic [RW+2:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic            sat_in;
    logic [RW+2:0]   rem_d;
    logic [RW-1:0]   root_d;

    if (s == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sat_in  = sat_i;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign sat_in  = sat_q[s-1];
    end

    always_comb begin
      logic [RW+2:0] rem_n;
      logic [RW+2:0] trial;
      int            idx;
      rem_d  = rem_in;
      root_d = root_in;
      for (int j = 0; j < SQ_STEP; j++) begin
        idx = RW - 1 - s * SQ_STEP - j;
        if (idx >= 0) begin
          rem_n = {rem_d[RW:0], 2'(rad_in >> (2 * idx))};
          trial = {1'b0, root_d, 2'b01};
          if (rem_n >= trial) begin
            rem_d  = rem_n - trial;
            root_d = {root_d[RW-2:0], 1'b1};
          end else begin
            rem_d  = rem_n;
            root_d = {root_d[RW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= rad_in;
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        sat_q[s]  <= sat_in;
      end
    end
  end

  assign root_o = root_q[SQ_STAGES-1];
  assign sat_o  = sat_q[SQ_STAGES-1];

endmodule

[rtl/aek_exp2.sv]
// Pipelined 2 to the power of minus y, at most one root-table multiply per stage.
// Depends on aek_pkg for widths and the root table.
module aek_exp2 (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [aek_pkg::YW-1:0] y_i,
  output logic [32:0]           e_o
);
  import aek_pkg::*;

  logic [32:0]   acc_q [1:32];
  logic [31:0]   f_q   [1:32];
  logic [NW-1:0] n_q   [1:32];
  logic [32:0]   e_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q[1] <= y_i[31] ? {1'b0, ROOT_TAB[1]} : 33'h1_0000_0000;
      f_q[1]   <= y_i[31:0];
      n_q[1]   <= y_i[YW-1:32];
    end
  end

  for (genvar k = 2; k <= 32; k++) begin : g_stage
    logic [64:0] prod;
    assign prod = acc_q[k-1] * ROOT_TAB[k];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k] <= f_q[k-1][32-k] ? prod[64:32] : acc_q[k-1];
        f_q[k]   <= f_q[k-1];
        n_q[k]   <= n_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= (n_q[32] >= NW'(33)) ? '0 : (acc_q[32] >> n_q[32]);
    end
  end

  assign e_o = e_q;

endmodule

[rtl/anisotropic_exponential_kernel.sv]
// Top level of the anisotropic exponential covariance kernel.
// Depends on aek_pkg, aek_sqrt, aek_exp2 and assert_macros.svh.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    first_x, first_y, second_x, second_y
//   out      output     out_valid_o / out_ready_i  covariance
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Without stalls, an accepted item's valid bit runs through the vld_q shift register and then sets out_valid_o.
// One item is accepted every cycle while the skid register is empty; the 31 root-table multiplies set the depth.
// A skid register behind the output keeps input flowing while one result waits.
// When the skid register is full, the whole pipeline holds; nothing is lost.
// Reset clears the valid bits and loads the configuration defaults.
`include "assert_macros.svh"

module anisotropic_exponential_kernel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] first_x_i,
  input  logic [31:0] first_y_i,
  input  logic [31:0] second_x_i,
  input  logic [31:0] second_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] covariance_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import aek_pkg::*;

  logic signed [31:0] l00_q, l01_q, l11_q;
  logic        [31:0] var_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l00_q <= 32'(1 << FRAC_BITS);
      l01_q <= '0;
      l11_q <= 32'(1 << FRAC_BITS);
      var_q <= 32'(1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_L00:      l00_q <= cfg_wdata_i;
        REG_L01:      l01_q <= cfg_wdata_i;
        REG_L11:      l11_q <= cfg_wdata_i;
        REG_VARIANCE: var_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_vld_q, out_vld_q;
  logic [31:0] skid_q, out_q;
  logic [LAT-1:0] vld_q;

  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic signed [32:0] dx_q, dy_q;
  logic signed [64:0] m00, m01, m11;
  logic signed [PW-1:0] s00_q, s01_q, s11_q;
  logic signed [PW:0] v0_q, v1_q;
  logic [PW:0] a_abs, b_abs;
  logic [AW-1:0] a_q, b_q;
  logic sat4_q, sat5_q, sat6_q;
  logic [2*AW-1:0] aa_q, bb_q;
  logic [RADW-1:0] rad_q;
  logic [RW-1:0] root;
  logic sq_sat;
  logic [RW-1:0] r_q;
  logic [ZHW-1:0] zh_q;
  logic [31:0] zl_q;
  logic [62:0] p1_q;
  logic [ZHW+30:0] p2_q;
  logic [YW-1:0] y_q;
  logic [32:0] e;
  logic [64:0] vprod;
  logic [31:0] cov_q;

  assign m00   = l00_q * dx_q;
  assign m01   = l01_q * dy_q;
  assign m11   = l11_q * dy_q;
  assign a_abs = v0_q[PW] ? (PW+1)'(-v0_q) : (PW+1)'(v0_q);
  assign b_abs = v1_q[PW] ? (PW+1)'(-v1_q) : (PW+1)'(v1_q);
  assign vprod = var_q * e;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q   <= $signed({first_x_i[31], first_x_i}) - $signed({second_x_i[31], second_x_i});
      dy_q   <= $signed({first_y_i[31], first_y_i}) - $signed({second_y_i[31], second_y_i});
      s00_q  <= m00[64:FRAC_BITS];
      s01_q  <= m01[64:FRAC_BITS];
      s11_q  <= m11[64:FRAC_BITS];
      v0_q   <= $signed({s00_q[PW-1], s00_q}) + $signed({s01_q[PW-1], s01_q});
      v1_q   <= $signed({s11_q[PW-1], s11_q});
      sat4_q <= (a_abs >= (PW+1)'(1) << AW) || (b_abs >= (PW+1)'(1) << AW);
      a_q    <= a_abs[AW-1:0];
      b_q    <= b_abs[AW-1:0];
      aa_q   <= a_q * a_q;
      bb_q   <= b_q * b_q;
      sat5_q <= sat4_q;
      rad_q  <= RADW'(aa_q) + RADW'(bb_q);
      sat6_q <= sat5_q;
      r_q    <= sq_sat ? RW'(1) << AW : root;
      zh_q   <= r_q[RW-1:FRAC_BITS+1];
      zl_q   <= 32'(r_q[FRAC_BITS:0]) << (31 - FRAC_BITS);
      p1_q   <= 63'(32'(r_q[FRAC_BITS:0]) << (31 - FRAC_BITS)) * 63'(LOG2E_FRAC);
      p2_q   <= r_q[RW-1:FRAC_BITS+1] * LOG2E_FRAC;
      y_q    <= YW'({zh_q, 32'h0}) + YW'(p2_q) + YW'(zl_q) + YW'(p1_q[62:32]);
      cov_q  <= vprod[63:32];
    end
  end

  aek_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .sat_i  (sat6_q),
    .root_o (root),
    .sat_o  (sq_sat)
  );

  aek_exp2 u_exp2 (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (y_q),
    .e_o   (e)
  );

  logic take, push;
  assign take = out_vld_q && out_ready_i;
  assign push = en && vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !take) begin
        skid_q <= cov_q;
      end else begin
        out_q <= cov_q;
      end
    end
  end

  assign out_valid_o  = out_vld_q;
  assign covariance_o = out_q;

  `AEK_ASSERT(a_skid_behind_out, skid_vld_q |-> out_vld_q)
  `AEK_ASSERT_NEXT(a_stall_holds, skid_vld_q, $stable(vld_q))
  `AEK_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, vld_q[0])
  `AEK_ASSERT_NEXT(a_drain_to_out, vld_q[LAT-1] && !skid_vld_q, out_vld_q)

endmodule

[test/anisotropic_exponential_kernel_test.sv]
// Testbench for the anisotropic exponential covariance kernel: random and edge point pairs,
// checked against a bit-exact fixed-point predictor held in a small scoreboard class.
// Depends on aek_pkg and the anisotropic_exponential_kernel RTL.
module anisotropic_exponential_kernel_test;
  import aek_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] first_x_i, first_y_i, second_x_i, second_y_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] covariance_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  int unsigned send_idle, recv_idle;
  longint unsigned cycle_count = 0;

  anisotropic_exponential_kernel i_dut (.*);

  class covariance_board;
    logic signed [31:0] l00, l01, l11;
    logic [31:0]        variance;
    logic [31:0]        pending[$];
    logic [63:0]        roots[0:32];
    int                 errors;

    function new();
      logic [63:0] r;
      l00 = 32'sh10000;
      l01 = 0;
      l11 = 32'sh10000;
      variance = 32'h10000;
      errors = 0;
      roots[0] = 0;
      roots[1] = int_sqrt(64'h8000_0000_0000_0000);
      for (int k = 2; k <= 32; k++) roots[k] = int_sqrt(roots[k-1] << 32);
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        REG_L00: l00 = val;
        REG_L01: l01 = val;
        REG_L11: l11 = val;
        REG_VARIANCE: variance = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] covariance_of(logic signed [31:0] ax, ay, bx, by);
      logic signed [63:0] dx, dy, v0, v1;
      logic signed [127:0] p;
      logic [63:0] a, b, r, z, zh, zl, y, f, acc;
      logic [127:0] prod;
      dx = 64'(ax) - 64'(bx);
      dy = 64'(ay) - 64'(by);
      p = 128'(dx) * 128'(l00);
      v0 = 64'(p >>> FRAC_BITS);
      p = 128'(dy) * 128'(l01);
      v0 = v0 + 64'(p >>> FRAC_BITS);
      p = 128'(dy) * 128'(l11);
      v1 = 64'(p >>> FRAC_BITS);
      a = v0 < 0 ? -v0 : v0;
      b = v1 < 0 ? -v1 : v1;
      if (a >= (64'd1 << 23) || b >= (64'd1 << 23)) r = 64'd1 << 23;
      else r = int_sqrt(a * a + b * b);
      z = r << (31 - FRAC_BITS);
      zh = z >> 32;
      zl = z & 64'hFFFF_FFFF;
      y = zh * 64'h1_7154_7653 + zl + ((zl * 64'h7154_7653) >> 32);
      f = y & 64'hFFFF_FFFF;
      acc = 64'd1 << 32;
      for (int k = 1; k <= 32; k++)
        if (f[32-k]) begin
          prod = 128'(acc) * 128'(roots[k]);
          acc = 64'(prod >> 32);
        end
      acc = ((y >> 32) >= 33) ? 64'd0 : acc >> (y >> 32);
      prod = 128'(variance) * 128'(acc);
      return 32'(prod >> 32);
    endfunction

    function void note_pair(logic [31:0] ax, ay, bx, by);
      pending.push_back(covariance_of(ax, ay, bx, by));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        $error("covariance: result %h with nothing expected", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("covariance: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  covariance_board board;

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(covariance_o);
    if (rst_ni && in_valid_i && in_ready_o)
      board.note_pair(first_x_i, first_y_i, second_x_i, second_y_i);
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return $urandom_range(32'h30000) - 32'h18000;
    endcase
  endfunction

  task automatic send_pair(logic [31:0] ax, ay, bx, by);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_x_i <= ax;
    first_y_i <= ay;
    second_x_i <= bx;
    second_y_i <= by;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [31:0] ax, ay;
    repeat (count) begin
      ax = pick_coord();
      ay = pick_coord();
      if ($urandom_range(9) == 0) send_pair(ax, ay, ax, ay);
      else send_pair(ax, ay, pick_coord(), pick_coord());
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LAT + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.set_reg(idx, val);
  endtask

  task automatic set_kernel(logic [31:0] a, b, c, v);
    write_reg(REG_L00, a);
    write_reg(REG_L01, b);
    write_reg(REG_L11, c);
    write_reg(REG_VARIANCE, v);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_L00;
    cfg_wdata_i = '0;
    first_x_i = '0;
    first_y_i = '0;
    second_x_i = '0;
    second_y_i = '0;
    send_idle = 0;
    recv_idle = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(32'h0, 32'h0, 32'h0, 32'h0);
    send_pair(32'h10000, 32'h20000, 32'h10000, 32'h20000);
    send_pair(32'h10000, 32'h0, 32'h0, 32'h0);
    send_pair(32'h0, 32'h10000, 32'h0, 32'h0);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pair(32'h7F_FFFF, 32'h0, 32'h0, 32'h0);
    send_pair(32'h80_0000, 32'h0, 32'h0, 32'h0);
    send_pair(32'h0, 32'h1, 32'h0, 32'h0);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_pair(32'h18000, 32'hFFFF_0000, 32'h0, 32'h0);
    drain();

    set_kernel(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_pair(32'h0, 32'h0, 32'h0, 32'h0);
    send_pair(32'h1, 32'h1, 32'h0, 32'h0);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_pair(32'h0, 32'h0, 32'h0, 32'h0);
    drain();
    set_kernel(32'h0, 32'h0, 32'h0, 32'h0);
    send_pair(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    drain();

    send_idle = 24;
    recv_idle = 88;
    set_kernel(32'h10000, 32'h0, 32'h10000, 32'h10000);
    send_random(300);
    drain();
    set_kernel(32'h8000, 32'hFFFF_C000, 32'h20000, $urandom());
    send_random(150);
    drain();

    send_idle = 88;
    recv_idle = 24;
    set_kernel($urandom_range(32'h40000) - 32'h20000, $urandom_range(32'h20000) - 32'h10000,
               $urandom_range(32'h40000) - 32'h20000, $urandom());
    send_random(200);
    drain();

    send_idle = 0;
    recv_idle = 0;
    set_kernel($urandom(), $urandom(), $urandom(), $urandom());
    send_random(100);
    drain();
    set_kernel(32'h1000, 32'h800, 32'hFFFF_F000, 32'hFFFF_FFFF);
    send_random(250);
    drain();
    set_kernel(32'h10000, 32'h10000, 32'h10000, 32'h10000);
    send_random(250);
    drain();

    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/aek_pkg.sv
rtl/aek_sqrt.sv
rtl/aek_exp2.sv
rtl/anisotropic_exponential_kernel.sv
test/anisotropic_exponential_kernel_test.sv
